// ===== sv/rpfc_pkg.sv =====
// Package with shared types, constants and format helpers for the pixel format converter.
package rpfc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_SRC_WIDTHS = 2'd0;
  localparam logic [1:0] REG_SRC_LAYOUT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTHS = 2'd2;
  localparam logic [1:0] REG_DST_LAYOUT = 2'd3;

  localparam int unsigned NUM_COMP = 4;
  localparam logic [19:0] SRC_WIDTHS_RST = 20'd8456;
  localparam logic [2:0]  SRC_LAYOUT_RST = 3'd0;
  localparam logic [19:0] DST_WIDTHS_RST = 20'd5317;
  localparam logic [2:0]  DST_LAYOUT_RST = 3'd4;

  // Placement of the four components (R, G, B, A) in one pixel word.
  typedef struct packed {
    logic [3:0][4:0] bits;
    logic [3:0][6:0] pos;
    logic [4:0]      nbytes;
  } plan_t;

  // Clamp a 5-bit width field to at most 16.
  function automatic logic [4:0] clamp_w(input logic [4:0] w);
    return (w > 5'd16) ? 5'd16 : w;
  endfunction

  // Bits a component occupies in the word.
  function automatic logic [6:0] span(input logic [4:0] w, input logic packed_l);
    logic [6:0] r;
    r = packed_l ? {2'b00, w} : {1'b0, 3'((w + 5'd7) >> 3), 3'b000};
    return r;
  endfunction

  // Work out field positions and the byte count from the width and layout registers.
  function automatic plan_t make_plan(input logic [19:0] widths, input logic [2:0] layout);
    plan_t p;
    logic [6:0] pos;
    logic [1:0] first_c;
    logic [1:0] last_c;
    for (int i = 0; i < NUM_COMP; i++) begin
      p.bits[i] = clamp_w(widths[5*i +: 5]);
    end
    first_c = layout[0] ? 2'd2 : 2'd0;
    last_c  = layout[0] ? 2'd0 : 2'd2;
    pos = 7'd0;
    p.pos = '0;
    if (p.bits[3] != 5'd0 && layout[1]) begin
      p.pos[3] = pos;
      pos = pos + span(p.bits[3], layout[2]);
    end
    p.pos[first_c] = pos;
    pos = pos + span(p.bits[first_c], layout[2]);
    p.pos[1] = pos;
    pos = pos + span(p.bits[1], layout[2]);
    p.pos[last_c] = pos;
    pos = pos + span(p.bits[last_c], layout[2]);
    if (p.bits[3] != 5'd0 && !layout[1]) begin
      p.pos[3] = pos;
      pos = pos + span(p.bits[3], layout[2]);
    end
    p.nbytes = 5'((pos + 7'd7) >> 3);
    return p;
  endfunction

  // Mask of the low w bits of a 16-bit value.
  function automatic logic [15:0] low_mask(input logic [4:0] w);
    logic [16:0] m;
    m = (17'd1 << w) - 17'd1;
    return m[15:0];
  endfunction

endpackage

// ===== sv/rpfc_lane.sv =====
// One component lane: extract, scale and place one component into its destination slot.
module rpfc_lane #(
  parameter int unsigned WordW = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WordW-1:0] src_i,
  input  logic [4:0]       s_bits_i,
  input  logic [6:0]       s_pos_i,
  input  logic [4:0]       d_bits_i,
  input  logic [6:0]       d_pos_i,
  output logic [WordW-1:0] placed_o
);

  logic [15:0] v_q, v_d;
  logic [15:0] smax_q, smax_d;
  logic [4:0]  s_q, d_q;
  logic [6:0]  dpos_q;
  logic [31:0] prod_q, prod_d;
  logic [15:0] half_q;
  logic [15:0] scaled;
  logic [15:0] res_d;
  logic [15:0] simple_q;
  logic        narrow_q;
  logic [4:0]  d2_q;
  logic [6:0]  dpos2_q;
  logic [WordW-1:0] place_q, place_d;
  logic [WordW-1:0] shifted;

  // Stage 1: pull out the source field.
  always_comb begin
    shifted = src_i >> s_pos_i;
    v_d     = (s_bits_i == 5'd0) ? 16'd0 : (shifted[15:0] & rpfc_pkg::low_mask(s_bits_i));
    smax_d  = rpfc_pkg::low_mask(s_bits_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      smax_q <= '0;
      s_q    <= '0;
      d_q    <= '0;
      dpos_q <= '0;
    end else if (en_i) begin
      v_q    <= v_d;
      smax_q <= smax_d;
      s_q    <= s_bits_i;
      d_q    <= d_bits_i;
      dpos_q <= d_pos_i;
    end
  end

  // Stage 2: widen by replication, or multiply for narrowing.
  logic [4:0] k, r;
  always_comb begin
    k = d_q - s_q;
    r = (s_q > k) ? (s_q - k) : 5'd0;
    prod_d = 32'(v_q) * 32'(rpfc_pkg::low_mask(d_q));
    if (s_q == d_q || s_q == 5'd0 || d_q == 5'd0) begin
      scaled = v_q;
    end else if (d_q > s_q) begin
      scaled = (v_q << k) | (v_q >> r);
    end else begin
      scaled = v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d + 32'(smax_q >> 1);
      half_q   <= smax_q;
      simple_q <= scaled;
      narrow_q <= (d_q < s_q) && (d_q != 5'd0);
      d2_q     <= d_q;
      dpos2_q  <= dpos_q;
    end
  end

  // Stage 3: divide by 2^s - 1 as q = (x + (x >> s) + 1) >> s, exact if x < 2^(2s) - 1.
  logic [4:0]  s2;
  logic [32:0] qx;
  always_comb begin
    s2 = 5'd0;
    for (int b = 0; b < 16; b++) begin
      if (half_q[b]) s2 = 5'(b + 1);
    end
    qx = (33'(prod_q) + 33'(prod_q >> s2) + 33'd1) >> s2;
    res_d = narrow_q ? qx[15:0] : simple_q;
    place_d = (d2_q == 5'd0) ? '0 :
              (WordW'(res_d & rpfc_pkg::low_mask(d2_q)) << dpos2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      place_q <= place_d;
    end
  end

  assign placed_o = place_q;

endmodule

// ===== sv/rgb_pixel_format_converter_top.sv =====
// Top level of the RGB pixel format converter: four component lanes and an output merge.
// The block converts one source pixel to the configured destination format.
// Input beats arrive on s_axis (tdata = src_word, 64 bits); results leave on m_axis
// (tdata = dst_word in bits 63:0, dst_bytes in bits 67:64, padded to 72 bits).
// Formats are set through the cfg write port: index 0 src_widths, 1 src_layout,
// 2 dst_widths, 3 dst_layout; other indexes are ignored. Write only while idle.
// The four lanes (R, G, B, A) each extract, scale and place one component; a merge
// stage ORs the lanes together and masks to the destination byte count.
// Each accepted input beat passes the three lane stages and the merge register.
// Throughput is one pixel per clock unless the receiver stalls; these form a
// four-stage pipeline, and the narrowing path uses one 16x16 multiply per lane.
// When the receiver stalls, the whole pipeline holds and s_axis_tready falls
// once the output register is full, so no beat is lost.
// Reset clears the pipeline valid bits and loads the default formats
// (8-8-8 byte-aligned RGB in, 5-6-5 packed RGB out).
module rgb_pixel_format_converter_top #(
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] src_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] dst_word, [67:64] dst_bytes, rest zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_wdata_i
);

  localparam int unsigned WordW = 64;
  localparam int unsigned NStage = 4;

  logic [19:0] src_w_q, dst_w_q;
  logic [2:0]  src_l_q, dst_l_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= rpfc_pkg::SRC_WIDTHS_RST;
      src_l_q <= rpfc_pkg::SRC_LAYOUT_RST;
      dst_w_q <= rpfc_pkg::DST_WIDTHS_RST;
      dst_l_q <= rpfc_pkg::DST_LAYOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpfc_pkg::REG_SRC_WIDTHS: src_w_q <= cfg_wdata_i;
        rpfc_pkg::REG_SRC_LAYOUT: src_l_q <= cfg_wdata_i[2:0];
        rpfc_pkg::REG_DST_WIDTHS: dst_w_q <= cfg_wdata_i;
        rpfc_pkg::REG_DST_LAYOUT: dst_l_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  rpfc_pkg::plan_t sp, dp;
  assign sp = rpfc_pkg::make_plan(src_w_q, src_l_q);
  assign dp = rpfc_pkg::make_plan(dst_w_q, dst_l_q);

  // Pipeline control: all stages advance together unless the output is stuck.
  logic [NStage-1:0] vld_q;
  logic adv;
  assign adv = !vld_q[NStage-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStage-2:0], s_axis_tvalid};
    end
  end

  // Source bytes at or beyond MAX_PIXEL_BYTES read as zero.
  logic [WordW-1:0] src_m;
  always_comb begin
    for (int b = 0; b < WordW / 8; b++) begin
      src_m[8*b +: 8] = (b < MAX_PIXEL_BYTES) ? s_axis_tdata[8*b +: 8] : 8'h00;
    end
  end

  logic [3:0][WordW-1:0] placed;
  for (genvar c = 0; c < 4; c++) begin : g_lane
    rpfc_lane #(.WordW(WordW)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .src_i   (src_m),
      .s_bits_i(sp.bits[c]),
      .s_pos_i (sp.pos[c]),
      .d_bits_i(dp.bits[c]),
      .d_pos_i (dp.pos[c]),
      .placed_o(placed[c])
    );
  end

  // Byte count tracks the lanes through three stages.
  logic [3:0] nb0, nb1_q, nb2_q, nb3_q;
  assign nb0 = (dp.nbytes > 5'(MAX_PIXEL_BYTES)) ? 4'(MAX_PIXEL_BYTES) : dp.nbytes[3:0];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nb1_q <= nb0;
      nb2_q <= nb1_q;
      nb3_q <= nb2_q;
    end
  end

  // Merge stage: combine lanes and clear bytes beyond the count.
  logic [WordW-1:0] merged, out_q;
  logic [3:0]       nbo_q;
  always_comb begin
    merged = placed[0] | placed[1] | placed[2] | placed[3];
    for (int b = 0; b < WordW / 8; b++) begin
      if (4'(b) >= nb3_q) merged[8*b +: 8] = 8'h00;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= merged;
      nbo_q <= nb3_q;
    end
  end

  assign m_axis_tvalid = vld_q[NStage-1];
  assign m_axis_tdata  = {4'h0, nbo_q, out_q};

  // Checks on pipeline flow.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output state");
  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[67:64] <= 4'(MAX_PIXEL_BYTES))
    else $error("byte count too large");

endmodule
